// ----- rtl/fpc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants for the payload cache
// Request codes, command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam int unsigned MaxEntriesDef = 16;

  localparam logic [2:0] REQ_PUT        = 3'd0;
  localparam logic [2:0] REQ_PUT_RETAIN = 3'd1;
  localparam logic [2:0] REQ_FIND_ID    = 3'd2;
  localparam logic [2:0] REQ_LOOKUP     = 3'd3;
  localparam logic [2:0] REQ_ERASE      = 3'd4;
  localparam logic [2:0] REQ_RETAIN     = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] payload_id;
    logic [63:0] hash_word_0;
    logic [63:0] hash_word_1;
    logic [63:0] hash_word_2;
    logic [63:0] hash_word_3;
    logic [63:0] payload_handle;
    logic [62:0] block_number;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] result_id;
    logic [63:0] result_handle;
    logic [62:0] result_block_number;
    logic        evicted_valid;
    logic [63:0] evicted_id;
    logic        last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, clear scan state
    logic scan;       // examine one slot (scan_r)
    logic evict;      // drop oldest, present its id
    logic commit;     // apply put / erase / retain update
    logic drop_step;  // retain: drop entry at sweep position if not kept
    logic emit;       // final result item
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic full_miss;   // put of new id on full cache
    logic drop_avail;  // retain has another entry to drop
    logic drop_report; // dropped entry is reported
    logic last_sent;   // final item already went out
  } sts_t;

endpackage

// ----- rtl/fpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpc_ctrl: request sequencer
// Steps scan, eviction, commit, drop sweep and final result per request.
// ----------------------------------------------------------------------------
module fpc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           out_busy,
  input  fpc_pkg::sts_t  sts,
  output fpc_pkg::cmd_t  cmd,
  output logic           idle
);
  import fpc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_EVICT = 7'b0000100,
    S_COMIT = 7'b0001000,
    S_DROP  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    idle = 1'b0;
    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        cmd.load = in_fire;
        if (in_fire) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = sts.full_miss ? S_EVICT : S_COMIT;
      end
      S_EVICT: begin
        if (!out_busy) begin
          cmd.evict = 1'b1;
          state_nxt = S_COMIT;
        end
      end
      S_COMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_DROP;
      end
      S_DROP: begin
        if (!sts.drop_avail) state_nxt = S_EMIT;
        else if (!(sts.drop_report && out_busy)) cmd.drop_step = 1'b1;
      end
      S_EMIT: begin
        if (sts.last_sent) begin
          state_nxt = S_WAIT;
        end else if (!out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

// ----- rtl/fpc_dp.sv -----
// ----------------------------------------------------------------------------
// fpc_dp: cache storage and slot scan datapath
// Slot fields in registers, FIFO order list, one-slot-per-cycle match scan.
// ----------------------------------------------------------------------------
module fpc_dp #(
  parameter int unsigned MAX_ENTRIES = fpc_pkg::MaxEntriesDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fpc_pkg::req_t  req_in,
  input  fpc_pkg::cmd_t  cmd,
  output fpc_pkg::sts_t  sts,
  output logic           rsp_push,
  output fpc_pkg::rsp_t  rsp
);
  import fpc_pkg::*;

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_ENTRIES - 1);

  logic [63:0]  id_r     [MAX_ENTRIES];
  logic [63:0]  handle_r [MAX_ENTRIES];
  logic [62:0]  bn_r     [MAX_ENTRIES];
  logic [255:0] hash_r   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r, hvalid_r;
  logic [IW-1:0] order_r [MAX_ENTRIES];
  logic [CW-1:0] count_r;

  req_t          req_r;
  logic [IW-1:0] scan_r;
  logic          scan_done_r;
  logic          id_hit_r, hash_hit_r;
  logic [IW-1:0] id_slot_r, hash_slot_r, free_slot_r;
  logic          free_hit_r;
  logic [MAX_ENTRIES-1:0] hclr_r;    // other slots holding the new hash
  logic [IW-1:0] keep_r;
  logic [CW-1:0] drop_pos_r;         // retain sweep position in order list
  logic          drop_on_r, drop_rep_r;
  logic          last_sent_r;
  rsp_t          rsp_nxt;

  logic [255:0] hash_in;
  logic         id_m, hash_m;
  logic         is_put, is_retain_any;
  logic         drop_cur_is_keep;

  assign hash_in = {req_r.hash_word_3, req_r.hash_word_2,
                    req_r.hash_word_1, req_r.hash_word_0};
  assign id_m   = valid_r[scan_r] && id_r[scan_r] == req_r.payload_id;
  assign hash_m = valid_r[scan_r] && hvalid_r[scan_r] && hash_r[scan_r] == hash_in;
  assign is_put = req_r.req_type == REQ_PUT || req_r.req_type == REQ_PUT_RETAIN;
  assign is_retain_any = req_r.req_type == REQ_PUT_RETAIN ||
                         (req_r.req_type == REQ_RETAIN && id_hit_r);
  assign drop_cur_is_keep = order_r[drop_pos_r[IW-1:0]] == keep_r;

  assign sts.scan_done   = scan_done_r;
  assign sts.full_miss   = is_put && !id_hit_r && count_r >= CNT_MAX;
  assign sts.drop_avail  = drop_on_r && drop_pos_r < count_r;
  assign sts.drop_report = drop_rep_r && !drop_cur_is_keep;
  assign sts.last_sent   = last_sent_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_in;
      scan_r <= '0;
      scan_done_r <= 1'b0;
      id_hit_r <= 1'b0;
      hash_hit_r <= 1'b0;
      free_hit_r <= 1'b0;
      hclr_r <= '0;
      id_slot_r <= '0;
      hash_slot_r <= '0;
      free_slot_r <= '0;
    end else if (cmd.evict) begin
      free_hit_r <= 1'b1;
      free_slot_r <= order_r[0];
    end else if (cmd.scan && !scan_done_r) begin
      if (id_m && !id_hit_r) begin
        id_hit_r <= 1'b1;
        id_slot_r <= scan_r;
      end
      if (hash_m && !hash_hit_r) begin
        hash_hit_r <= 1'b1;
        hash_slot_r <= scan_r;
      end
      if (hash_m) hclr_r[scan_r] <= 1'b1;
      if (!valid_r[scan_r] && !free_hit_r) begin
        free_hit_r <= 1'b1;
        free_slot_r <= scan_r;
      end
      if (scan_r == IDX_LAST) scan_done_r <= 1'b1;
      else scan_r <= scan_r + 1'b1;
    end
  end

  // order list removal helper: each position is compacted independently
  // (it checks whether the removed slot sits at or before that position)
  function automatic logic [IW-1:0] pick_after_remove(
    input logic [IW-1:0] ord [MAX_ENTRIES], input logic [IW-1:0] s,
    input logic [CW-1:0] n, input int unsigned p);
    logic [IW-1:0] r;
    r = ord[p];
    for (int unsigned i = 0; i < MAX_ENTRIES; i++) begin
      if (CW'(i) < n && ord[i] == s && i <= p && p + 1 < MAX_ENTRIES)
        r = ord[p + 1];
    end
    return r;
  endfunction

  logic [IW-1:0] vict;
  logic [IW-1:0] new_slot;
  assign vict = order_r[0];
  assign new_slot = id_hit_r ? id_slot_r : (free_hit_r ? free_slot_r : vict);

  // result item; the keep entry sits at the tail of the order list during a
  // put_and_retain sweep, so the drop just before it is the final item
  always_comb begin
    rsp_nxt = '0;
    if (cmd.evict) begin
      rsp_nxt.evicted_valid = 1'b1;
      rsp_nxt.evicted_id = id_r[vict];
      rsp_nxt.last = req_r.req_type == REQ_PUT || MAX_ENTRIES == 1;
    end else if (cmd.drop_step) begin
      rsp_nxt.evicted_valid = 1'b1;
      rsp_nxt.evicted_id = id_r[order_r[drop_pos_r[IW-1:0]]];
      rsp_nxt.last = drop_pos_r == count_r - CW'(2);
    end else if (cmd.emit) begin
      rsp_nxt.last = 1'b1;
      case (req_r.req_type)
        REQ_FIND_ID: begin
          rsp_nxt.found = id_hit_r;
          if (id_hit_r) rsp_nxt.result_handle = handle_r[id_slot_r];
        end
        REQ_LOOKUP: begin
          rsp_nxt.found = hash_hit_r;
          if (hash_hit_r) begin
            rsp_nxt.result_id = id_r[hash_slot_r];
            rsp_nxt.result_handle = handle_r[hash_slot_r];
            rsp_nxt.result_block_number = bn_r[hash_slot_r];
          end
        end
        REQ_ERASE, REQ_RETAIN: rsp_nxt.found = id_hit_r;
        default: ;
      endcase
    end
  end

  assign rsp_push = cmd.evict || (cmd.drop_step && drop_rep_r && !drop_cur_is_keep) ||
                    cmd.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hvalid_r <= '0;
      count_r <= '0;
      drop_on_r <= 1'b0;
      drop_rep_r <= 1'b0;
      last_sent_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        drop_on_r <= 1'b0;
        drop_pos_r <= '0;
      end
      if (cmd.load) last_sent_r <= 1'b0;
      else if (rsp_push && rsp_nxt.last) last_sent_r <= 1'b1;
      if (rsp_push) rsp <= rsp_nxt;
      if (cmd.evict) begin
        valid_r[vict] <= 1'b0;
        hvalid_r[vict] <= 1'b0;
        for (int unsigned p = 0; p < MAX_ENTRIES; p++)
          order_r[p] <= pick_after_remove(order_r, vict, count_r, p);
        count_r <= count_r - 1'b1;
      end
      if (cmd.commit) begin
        keep_r <= is_put ? new_slot : id_slot_r;
        drop_rep_r <= req_r.req_type == REQ_PUT_RETAIN;
        drop_on_r <= is_retain_any;
        if (is_put) begin
          for (int unsigned i = 0; i < MAX_ENTRIES; i++)
            if (hclr_r[i] && IW'(i) != new_slot) hvalid_r[i] <= 1'b0;
          valid_r[new_slot] <= 1'b1;
          hvalid_r[new_slot] <= 1'b1;
          id_r[new_slot] <= req_r.payload_id;
          handle_r[new_slot] <= req_r.payload_handle;
          bn_r[new_slot] <= req_r.block_number;
          hash_r[new_slot] <= hash_in;
          if (id_hit_r) begin
            for (int unsigned p = 0; p < MAX_ENTRIES; p++)
              order_r[p] <= (CW'(p) == count_r - 1'b1) ? new_slot :
                            pick_after_remove(order_r, new_slot, count_r, p);
          end else begin
            order_r[count_r[IW-1:0]] <= new_slot;
            count_r <= count_r + 1'b1;
          end
        end else if (req_r.req_type == REQ_ERASE && id_hit_r) begin
          valid_r[id_slot_r] <= 1'b0;
          hvalid_r[id_slot_r] <= 1'b0;
          for (int unsigned p = 0; p < MAX_ENTRIES; p++)
            order_r[p] <= pick_after_remove(order_r, id_slot_r, count_r, p);
          count_r <= count_r - 1'b1;
        end else if (req_r.req_type == REQ_RETAIN && id_hit_r) begin
          hvalid_r[id_slot_r] <= 1'b1;
          hash_r[id_slot_r] <= hash_in;
        end
      end
      if (cmd.drop_step) begin
        if (!drop_cur_is_keep) begin
          valid_r[order_r[drop_pos_r[IW-1:0]]] <= 1'b0;
          hvalid_r[order_r[drop_pos_r[IW-1:0]]] <= 1'b0;
        end
        drop_pos_r <= drop_pos_r + 1'b1;
      end
      if (drop_on_r && !sts.drop_avail && !cmd.commit) begin
        drop_on_r <= 1'b0;
        order_r[0] <= keep_r;
        count_r <= CW'(1);
      end
    end
  end
endmodule

// ----- rtl/fifo_payload_cache_with_hash_index.sv -----
// ----------------------------------------------------------------------------
// fifo_payload_cache_with_hash_index: FIFO-replacement payload cache
//
// Channel  Dir  Bytes  Contents
// in_      in   57     req_type, payload_id, hash words 0..3, handle, block
// out_     out  32     result ids/handles, tuser {evicted_valid, found}, tlast
//
// Requests are taken only while the sequencer is idle, never before the last
// is through; the slot match scan looks at one slot a cycle. A retain sweeps
// every entry in FIFO order. For a plain put an eviction item replaces the
// final item. Results wait in the output register; the sequencer pauses while
// it is full. Reset clears valid bits and count.
// ----------------------------------------------------------------------------
module fifo_payload_cache_with_hash_index #(
  parameter int unsigned MAX_ENTRIES = fpc_pkg::MaxEntriesDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type[2:0], payload_id, hash_word_0..3, payload_handle,
  // block_number[449:387]
  input  logic [455:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_id[63:0], result_handle[127:64], result_block_number[190:128],
  // evicted_id[254:191]
  output logic [255:0] out_tdata,
  // found[0], evicted_valid[1]
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);
  import fpc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  req_t req;
  rsp_t rsp;
  logic rsp_push, idle, in_fire;

  assign req.req_type       = in_tdata[2:0];
  assign req.payload_id     = in_tdata[66:3];
  assign req.hash_word_0    = in_tdata[130:67];
  assign req.hash_word_1    = in_tdata[194:131];
  assign req.hash_word_2    = in_tdata[258:195];
  assign req.hash_word_3    = in_tdata[322:259];
  assign req.payload_handle = in_tdata[386:323];
  assign req.block_number   = in_tdata[449:387];

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;

  fpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(out_tvalid),
    .sts(sts), .cmd(cmd), .idle(idle)
  );

  fpc_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .req_in(req), .cmd(cmd), .sts(sts),
    .rsp_push(rsp_push), .rsp(rsp)
  );

  logic vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (rsp_push) vld_r <= 1'b1;
    else if (out_tready) vld_r <= 1'b0;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {1'b0, rsp.evicted_id, rsp.result_block_number,
                       rsp.result_handle, rsp.result_id};
  assign out_tuser  = {rsp.evicted_valid, rsp.found};
  assign out_tlast  = rsp.last;
endmodule

// ----- rtl/fpc_chk.sv -----
// ----------------------------------------------------------------------------
// fpc_chk: port checker for the payload cache
// Watches handshake and eviction item contents on the top-level ports.
// ----------------------------------------------------------------------------
module fpc_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [255:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");
  a_evzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[190:0] == '0)
    else $error("eviction item with result fields");
  a_ev_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0])
    else $error("eviction item with found");
endmodule

bind fifo_payload_cache_with_hash_index fpc_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
